// ===== hdl/y2b_pkg.sv =====
// shared types, widths and constants for the yuyv to bgr converter
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps
`default_nettype none

package y2b_pkg;

    localparam int COEF_W  = 18;
    localparam int PIX_W   = 8;
    localparam int DIFF_W  = PIX_W + 1;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 27;
    localparam int SUM_W   = 28;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 4 * PIX_W;
    localparam int OUT_W   = 6 * PIX_W;

    localparam logic [PIX_W-1:0]  CHROMA_OFFSET = 8'd128;
    localparam logic [PIX_W-1:0]  PIX_MAX       = 8'd255;

    localparam logic [COEF_W-1:0] COEF_U_TO_BLUE_RST  = 18'd113538;
    localparam logic [COEF_W-1:0] COEF_U_TO_GREEN_RST = 18'd45744;
    localparam logic [COEF_W-1:0] COEF_V_TO_GREEN_RST = 18'd46080;
    localparam logic [COEF_W-1:0] COEF_V_TO_RED_RST   = 18'd89831;

    localparam logic [IDX_W-1:0]  REG_U_TO_BLUE  = 2'd0;
    localparam logic [IDX_W-1:0]  REG_U_TO_GREEN = 2'd1;
    localparam logic [IDX_W-1:0]  REG_V_TO_GREEN = 2'd2;
    localparam logic [IDX_W-1:0]  REG_V_TO_RED   = 2'd3;

    typedef struct packed {
        logic [COEF_W-1:0] u_to_blue;
        logic [COEF_W-1:0] u_to_green;
        logic [COEF_W-1:0] v_to_green;
        logic [COEF_W-1:0] v_to_red;
    } coef_set_t;

    // unpacked macropixel with chroma already re-centered
    typedef struct packed {
        logic [PIX_W-1:0]         luma_first;
        logic [PIX_W-1:0]         luma_second;
        logic signed [DIFF_W-1:0] du;
        logic signed [DIFF_W-1:0] dv;
        logic                     frame_end;
    } mpix_t;

    typedef struct packed {
        logic [PIX_W-1:0]         luma_first;
        logic [PIX_W-1:0]         luma_second;
        logic signed [PROD_W-1:0] u_blue;
        logic signed [PROD_W-1:0] u_green;
        logic signed [PROD_W-1:0] v_green;
        logic signed [PROD_W-1:0] v_red;
        logic                     frame_end;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] blue_first;
        logic signed [SUM_W-1:0] green_first;
        logic signed [SUM_W-1:0] red_first;
        logic signed [SUM_W-1:0] blue_second;
        logic signed [SUM_W-1:0] green_second;
        logic signed [SUM_W-1:0] red_second;
        logic                    frame_end;
    } sum_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] blue_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] red_second;
        logic             frame_end;
    } pix_out_t;

    // floor at the binary point and saturate to 0..255
    function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] r;
        if (s[SUM_W-1])
            r = '0;
        else if (s[SUM_W-2:FRAC_W+PIX_W] != '0)
            r = PIX_MAX;
        else
            r = s[FRAC_W+PIX_W-1:FRAC_W];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/y2b_mult.sv =====
// multiply stage: chroma differences times the four weights, one register
// depends on y2b_pkg
`timescale 1ns / 1ps
`default_nettype none

module y2b_mult (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire y2b_pkg::coef_set_t  coef,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire y2b_pkg::mpix_t      in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output y2b_pkg::prod_t           out_data
);

    logic            valid_reg;
    y2b_pkg::prod_t  prod_reg;
    y2b_pkg::prod_t  prod_next;
    logic            load;

    logic signed [y2b_pkg::PROD_W:0] p_ub;
    logic signed [y2b_pkg::PROD_W:0] p_ug;
    logic signed [y2b_pkg::PROD_W:0] p_vg;
    logic signed [y2b_pkg::PROD_W:0] p_vr;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        p_ub = $signed({1'b0, coef.u_to_blue})  * in_data.du;
        p_ug = $signed({1'b0, coef.u_to_green}) * in_data.du;
        p_vg = $signed({1'b0, coef.v_to_green}) * in_data.dv;
        p_vr = $signed({1'b0, coef.v_to_red})   * in_data.dv;
        // magnitude stays below 2^25, so the top bit is redundant
        prod_next.luma_first  = in_data.luma_first;
        prod_next.luma_second = in_data.luma_second;
        prod_next.u_blue      = p_ub[y2b_pkg::PROD_W-1:0];
        prod_next.u_green     = p_ug[y2b_pkg::PROD_W-1:0];
        prod_next.v_green     = p_vg[y2b_pkg::PROD_W-1:0];
        prod_next.v_red       = p_vr[y2b_pkg::PROD_W-1:0];
        prod_next.frame_end   = in_data.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/y2b_sum_clamp.sv =====
// sum stage and clamp stage: builds the six channel sums, then floors
// and saturates them into the output register; depends on y2b_pkg
`timescale 1ns / 1ps
`default_nettype none

module y2b_sum_clamp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire y2b_pkg::prod_t    in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output y2b_pkg::pix_out_t      out_data
);

    logic                  sum_valid_reg;
    y2b_pkg::sum_t         sum_reg;
    y2b_pkg::sum_t         sum_next;
    logic                  out_valid_reg;
    y2b_pkg::pix_out_t     out_reg;
    y2b_pkg::pix_out_t     out_next;
    logic                  sum_ready;
    logic                  load_sum;
    logic                  load_out;

    logic signed [y2b_pkg::SUM_W-1:0] base_first;
    logic signed [y2b_pkg::SUM_W-1:0] base_second;
    logic signed [y2b_pkg::SUM_W-1:0] ub;
    logic signed [y2b_pkg::SUM_W-1:0] ug;
    logic signed [y2b_pkg::SUM_W-1:0] vg;
    logic signed [y2b_pkg::SUM_W-1:0] vr;

    assign sum_ready = !out_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;
    assign load_sum  = in_valid && in_ready;
    assign load_out  = sum_valid_reg && sum_ready;

    always_comb
    begin
        base_first  = $signed({4'b0, in_data.luma_first, {y2b_pkg::FRAC_W{1'b0}}});
        base_second = $signed({4'b0, in_data.luma_second, {y2b_pkg::FRAC_W{1'b0}}});
        ub = $signed({in_data.u_blue[y2b_pkg::PROD_W-1], in_data.u_blue});
        ug = $signed({in_data.u_green[y2b_pkg::PROD_W-1], in_data.u_green});
        vg = $signed({in_data.v_green[y2b_pkg::PROD_W-1], in_data.v_green});
        vr = $signed({in_data.v_red[y2b_pkg::PROD_W-1], in_data.v_red});
        sum_next.blue_first   = base_first + ub;
        sum_next.green_first  = base_first - ug - vg;
        sum_next.red_first    = base_first + vr;
        sum_next.blue_second  = base_second + ub;
        sum_next.green_second = base_second - ug - vg;
        sum_next.red_second   = base_second + vr;
        sum_next.frame_end    = in_data.frame_end;
    end

    always_comb
    begin
        out_next.blue_first   = y2b_pkg::clamp_chan(sum_reg.blue_first);
        out_next.green_first  = y2b_pkg::clamp_chan(sum_reg.green_first);
        out_next.red_first    = y2b_pkg::clamp_chan(sum_reg.red_first);
        out_next.blue_second  = y2b_pkg::clamp_chan(sum_reg.blue_second);
        out_next.green_second = y2b_pkg::clamp_chan(sum_reg.green_second);
        out_next.red_second   = y2b_pkg::clamp_chan(sum_reg.red_second);
        out_next.frame_end    = sum_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sum_valid_reg <= in_valid;
            if (sum_ready)
                out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
            sum_reg <= sum_next;
        if (load_out)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // negative sum saturates to zero
    a_neg_clamps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && sum_reg.blue_first[y2b_pkg::SUM_W-1]) |=> (out_data.blue_first == '0))
        else $error("negative blue sum not clamped to zero");

    // sum of 256 or more saturates to full scale
    a_big_clamps_max: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !sum_reg.red_second[y2b_pkg::SUM_W-1]
         && (sum_reg.red_second[y2b_pkg::SUM_W-2:y2b_pkg::FRAC_W+y2b_pkg::PIX_W] != '0))
        |=> (out_data.red_second == y2b_pkg::PIX_MAX))
        else $error("large red sum not clamped to full scale");

    // a held sum stage keeps its contents until the output side frees up
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && !sum_ready) |=> (sum_valid_reg && $stable(sum_reg)))
        else $error("sum stage changed while stalled");

endmodule

`default_nettype wire

// ===== hdl/yuyv_to_bgr_converter_top.sv =====
// yuyv macropixel to two bgr24 pixels, top level with weight registers and input stage
// depends on y2b_pkg, y2b_mult, y2b_sum_clamp
//
// usage:
//   s_axis: one yuyv macropixel per beat; tdata holds Y0, U, Y1, V from the
//           lowest byte up, tlast marks the last macropixel of a frame
//   m_axis: two bgr pixels per beat; tdata holds B0, G0, R0, B1, G1, R1 from
//           the lowest byte up, tlast is the copied frame-end mark
//   cfg:    cfg_wr_en with cfg_index 0..3 writes u->blue, u->green, v->green,
//           v->red weights (unsigned, 16 fraction bits); write only while idle
// timing:
//   four register stages (input, multiply, sum, clamp/output); a beat
//   accepted into the input register moves on through the multiply and
//   sum registers to the output register; throughput is one macropixel per
//   clock while m_tready is high, every stage then taking a beat each cycle
//   each stage has its own valid bit, so bubbles close up under back-pressure
// reset: all stages empty, weights return to their default values
// stall: with m_tready low the output beat holds; upstream stages keep
//   filling until all four are full, then s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_bgr_converter_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // luma_first, chroma_blue_diff, luma_second, chroma_red_diff
    input  wire logic [y2b_pkg::IN_W-1:0]     s_axis_tdata,
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // blue_first, green_first, red_first, blue_second, green_second, red_second
    output logic [y2b_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tlast,
    input  wire logic                         cfg_wr_en,
    input  wire logic [y2b_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [y2b_pkg::COEF_W-1:0]   cfg_wdata
);

    y2b_pkg::coef_set_t  coef_reg;
    logic                in_valid_reg;
    y2b_pkg::mpix_t      in_reg;
    y2b_pkg::mpix_t      in_next;
    logic                mult_ready;
    logic                mult_valid;
    logic                sum_ready;
    y2b_pkg::prod_t      mult_data;
    y2b_pkg::pix_out_t   pix_data;
    logic                load_in;

    // weight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.u_to_blue  <= y2b_pkg::COEF_U_TO_BLUE_RST;
            coef_reg.u_to_green <= y2b_pkg::COEF_U_TO_GREEN_RST;
            coef_reg.v_to_green <= y2b_pkg::COEF_V_TO_GREEN_RST;
            coef_reg.v_to_red   <= y2b_pkg::COEF_V_TO_RED_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                y2b_pkg::REG_U_TO_BLUE:  coef_reg.u_to_blue  <= cfg_wdata;
                y2b_pkg::REG_U_TO_GREEN: coef_reg.u_to_green <= cfg_wdata;
                y2b_pkg::REG_V_TO_GREEN: coef_reg.v_to_green <= cfg_wdata;
                y2b_pkg::REG_V_TO_RED:   coef_reg.v_to_red   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage: unpack the beat and re-center the chroma bytes
    always_comb
    begin
        in_next.luma_first  = s_axis_tdata[7:0];
        in_next.luma_second = s_axis_tdata[23:16];
        in_next.du = $signed({1'b0, s_axis_tdata[15:8]}) - $signed({1'b0, y2b_pkg::CHROMA_OFFSET});
        in_next.dv = $signed({1'b0, s_axis_tdata[31:24]}) - $signed({1'b0, y2b_pkg::CHROMA_OFFSET});
        in_next.frame_end   = s_axis_tlast;
    end

    assign s_axis_tready = !in_valid_reg || mult_ready;
    assign load_in       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            in_reg <= in_next;
    end

    y2b_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (mult_ready),
        .in_data   (in_reg),
        .out_valid (mult_valid),
        .out_ready (sum_ready),
        .out_data  (mult_data)
    );

    y2b_sum_clamp u_sum_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (sum_ready),
        .in_data   (mult_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (pix_data)
    );

    assign m_axis_tdata = {pix_data.red_second, pix_data.green_second, pix_data.blue_second,
                           pix_data.red_first, pix_data.green_first, pix_data.blue_first};
    assign m_axis_tlast = pix_data.frame_end;

endmodule

`default_nettype wire

// ===== dv/yuyv_to_bgr_converter_top_test.sv =====
// self-checking test for yuyv_to_bgr_converter_top: random and directed macropixels,
// weight register phases, stalls on both streams; an in-line predictor checks every beat
// depends on y2b_pkg and the hdl sources of the converter
`timescale 1ns / 1ps

module yuyv_to_bgr_converter_top_test;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PIPE_SLACK      = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_PAIRS     = 140;
    localparam logic [y2b_pkg::COEF_W-1:0] COEF_MAX = '1;
    localparam logic [y2b_pkg::COEF_W-1:0] COEF_ONE = 18'd65536;

    typedef struct {
        logic [y2b_pkg::PIX_W-1:0] luma_first;
        logic [y2b_pkg::PIX_W-1:0] chroma_blue_diff;
        logic [y2b_pkg::PIX_W-1:0] luma_second;
        logic [y2b_pkg::PIX_W-1:0] chroma_red_diff;
        logic                      frame_end;
    } yuyv_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [y2b_pkg::IN_W-1:0]      s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [y2b_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          cfg_wr_en;
    logic [y2b_pkg::IDX_W-1:0]     cfg_index;
    logic [y2b_pkg::COEF_W-1:0]    cfg_wdata;

    y2b_pkg::coef_set_t  weights;
    y2b_pkg::pix_out_t   expected_pixels[$];
    int                  fail_count;
    int                  cycle_count;
    bit                  tx_idle_on;
    bit                  rx_idle_on;
    bit                  hold_off_req;
    int                  rx_stall_left;

    yuyv_to_bgr_converter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic logic [y2b_pkg::PIX_W-1:0] saturate_channel(input longint acc);
        longint whole;
        if (acc < 0)
            return '0;
        whole = acc >>> y2b_pkg::FRAC_W;
        if (whole > longint'(y2b_pkg::PIX_MAX))
            return y2b_pkg::PIX_MAX;
        return whole[y2b_pkg::PIX_W-1:0];
    endfunction

    // returns {red, green, blue} of one pixel
    function automatic logic [3*y2b_pkg::PIX_W-1:0] convert_pixel(
        input logic [y2b_pkg::PIX_W-1:0] luma, input longint du, input longint dv);
        longint base;
        logic [y2b_pkg::PIX_W-1:0] b, g, r;
        base = longint'(luma) * (longint'(1) << y2b_pkg::FRAC_W);
        b = saturate_channel(base + longint'(weights.u_to_blue) * du);
        g = saturate_channel(base - longint'(weights.u_to_green) * du
                                  - longint'(weights.v_to_green) * dv);
        r = saturate_channel(base + longint'(weights.v_to_red) * dv);
        return {r, g, b};
    endfunction

    function automatic y2b_pkg::pix_out_t convert_pair(input yuyv_t px);
        y2b_pkg::pix_out_t res;
        longint du, dv;
        du = longint'(px.chroma_blue_diff) - longint'(y2b_pkg::CHROMA_OFFSET);
        dv = longint'(px.chroma_red_diff) - longint'(y2b_pkg::CHROMA_OFFSET);
        {res.red_first, res.green_first, res.blue_first} =
            convert_pixel(px.luma_first, du, dv);
        {res.red_second, res.green_second, res.blue_second} =
            convert_pixel(px.luma_second, du, dv);
        res.frame_end = px.frame_end;
        return res;
    endfunction

    // bytes lean toward the extremes and the chroma offset now and then
    function automatic logic [y2b_pkg::PIX_W-1:0] random_byte();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return y2b_pkg::PIX_MAX;
            2:       return y2b_pkg::CHROMA_OFFSET;
            default: return y2b_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic yuyv_t random_pair();
        yuyv_t px;
        px.luma_first       = random_byte();
        px.chroma_blue_diff = random_byte();
        px.luma_second      = random_byte();
        px.chroma_red_diff  = random_byte();
        px.frame_end        = ($urandom_range(0, 7) == 0);
        return px;
    endfunction

    function automatic logic [y2b_pkg::COEF_W-1:0] random_weight();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return COEF_MAX;
            default: return y2b_pkg::COEF_W'($urandom_range(0, 262143));
        endcase
    endfunction

    // called at a rising edge; returns at the edge that takes the beat, valid still high
    task automatic send_pair(input yuyv_t px);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.chroma_red_diff, px.luma_second, px.chroma_blue_diff,
                          px.luma_first};
        s_axis_tlast  <= px.frame_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_pixels.push_back(convert_pair(px));
    endtask

    task automatic send_values(input logic [y2b_pkg::PIX_W-1:0] y0,
                               input logic [y2b_pkg::PIX_W-1:0] u,
                               input logic [y2b_pkg::PIX_W-1:0] y1,
                               input logic [y2b_pkg::PIX_W-1:0] v,
                               input logic last);
        yuyv_t px;
        px.luma_first       = y0;
        px.chroma_blue_diff = u;
        px.luma_second      = y1;
        px.chroma_red_diff  = v;
        px.frame_end        = last;
        send_pair(px);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // only while idle: all four weights back to back
    task automatic load_weights(input y2b_pkg::coef_set_t w);
        logic [y2b_pkg::IDX_W-1:0]  idx[4];
        logic [y2b_pkg::COEF_W-1:0] val[4];
        idx = '{y2b_pkg::REG_U_TO_BLUE, y2b_pkg::REG_U_TO_GREEN,
                y2b_pkg::REG_V_TO_GREEN, y2b_pkg::REG_V_TO_RED};
        val = '{w.u_to_blue, w.u_to_green, w.v_to_green, w.v_to_red};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        weights = w;
    endtask

    task automatic test_default_weights();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_values(8'd0,   8'd128, 8'd0,   8'd128, 1'b0);
        send_values(8'd255, 8'd128, 8'd255, 8'd128, 1'b1);
        send_values(8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
        send_values(8'd255, 8'd255, 8'd0,   8'd255, 1'b0);
        send_values(8'd0,   8'd255, 8'd255, 8'd0,   1'b1);
        send_values(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_values(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
        send_values(8'd128, 8'd0,   8'd128, 8'd255, 1'b1);
        send_values(8'd128, 8'd255, 8'd128, 8'd0,   1'b0);
        send_values(8'd1,   8'd127, 8'd254, 8'd129, 1'b1);
        send_values(8'd170, 8'd85,  8'd85,  8'd170, 1'b0);
        send_values(8'd85,  8'd170, 8'd170, 8'd85,  1'b1);
        wait_drained();
    endtask

    task automatic test_weight_extremes();
        y2b_pkg::coef_set_t w;
        // zero weights pass luma straight to every channel
        w = '{default: '0};
        load_weights(w);
        send_values(8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
        send_values(8'd77,  8'd200, 8'd3,   8'd9,   1'b0);
        wait_drained();
        // unity weights hit the clamp exactly at the edges
        w = '{default: COEF_ONE};
        load_weights(w);
        send_values(8'd129, 8'd255, 8'd128, 8'd255, 1'b0);
        send_values(8'd0,   8'd127, 8'd1,   8'd127, 1'b1);
        send_values(8'd128, 8'd0,   8'd127, 8'd0,   1'b0);
        wait_drained();
        w = '{default: COEF_MAX};
        load_weights(w);
        send_values(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_values(8'd0,   8'd255, 8'd255, 8'd0,   1'b1);
        send_values(8'd128, 8'd129, 8'd127, 8'd127, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        y2b_pkg::coef_set_t w;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: w = '{y2b_pkg::COEF_U_TO_BLUE_RST, y2b_pkg::COEF_U_TO_GREEN_RST,
                         y2b_pkg::COEF_V_TO_GREEN_RST, y2b_pkg::COEF_V_TO_RED_RST};
                2: w = '{default: COEF_MAX};
                default: w = '{random_weight(), random_weight(), random_weight(),
                               random_weight()};
            endcase
            load_weights(w);
            // one phase runs back to back with no gaps at all
            tx_idle_on = (ph != 3);
            rx_idle_on = (ph != 3) && (ph != 1);
            for (int n = 0; n < PHASE_PAIRS; n++)
                send_pair(random_pair());
            wait_drained();
        end
        load_weights('{y2b_pkg::COEF_U_TO_BLUE_RST, y2b_pkg::COEF_U_TO_GREEN_RST,
                       y2b_pkg::COEF_V_TO_GREEN_RST, y2b_pkg::COEF_V_TO_RED_RST});
    endtask

    // output held off long enough that the pipe fills and input stalls
    task automatic test_output_hold_off();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b1;
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_pair(random_pair());
        wait_drained();
    endtask

    // sender stops until every result is out, then carries on
    task automatic test_sender_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int n = 0; n < 20; n++)
            send_pair(random_pair());
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        for (int n = 0; n < 20; n++)
            send_pair(random_pair());
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_off_req)
            begin
                hold_off_req  = 1'b0;
                rx_stall_left = HOLD_OFF_CYCLES;
            end
            else if (rx_stall_left == 0 && rx_idle_on)
                rx_stall_left = pick_gap();
            if (rx_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name,
                                        input logic [y2b_pkg::PIX_W-1:0] exp_v,
                                        input logic [y2b_pkg::PIX_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        y2b_pkg::pix_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("output beat with no pending macropixel: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("blue_first",    want.blue_first,   m_axis_tdata[7:0]);
                check_field("green_first",   want.green_first,  m_axis_tdata[15:8]);
                check_field("red_first",     want.red_first,    m_axis_tdata[23:16]);
                check_field("blue_second",   want.blue_second,  m_axis_tdata[31:24]);
                check_field("green_second",  want.green_second, m_axis_tdata[39:32]);
                check_field("red_second",    want.red_second,   m_axis_tdata[47:40]);
                check_field("frame_end_out", y2b_pkg::PIX_W'(want.frame_end),
                            y2b_pkg::PIX_W'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL yuyv_to_bgr_converter_top");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        hold_off_req  = 1'b0;
        rx_stall_left = 0;
        weights       = '{y2b_pkg::COEF_U_TO_BLUE_RST, y2b_pkg::COEF_U_TO_GREEN_RST,
                          y2b_pkg::COEF_V_TO_GREEN_RST, y2b_pkg::COEF_V_TO_RED_RST};
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= y2b_pkg::REG_U_TO_BLUE;
        cfg_wdata     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_weights();
        test_weight_extremes();
        test_random_phases();
        test_output_hold_off();
        test_sender_pause();

        if (fail_count == 0)
            $display("PASS yuyv_to_bgr_converter_top");
        else
            $display("FAIL yuyv_to_bgr_converter_top");
        $finish;
    end

endmodule
